// File: rtl/alarm_timer_priority_dispatcher_unit_defines.svh
// ----------------------------------------------------------------------------
// Alarm timer dispatcher assertion macros
// Concurrent assertion wrappers on clk with rst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef ALARM_TIMER_PRIORITY_DISPATCHER_UNIT_DEFINES_SVH
`define ALARM_TIMER_PRIORITY_DISPATCHER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ATPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`define ATPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ATPD_ASSERT(lbl, prop, msg)
`define ATPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/atpd_pkg.sv
// ----------------------------------------------------------------------------
// Alarm timer dispatcher package
// Operation codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package atpd_pkg;

  localparam int OP_W       = 3;
  localparam int TASK_W     = 5;
  localparam int ALARM_ID_W = 3;
  localparam int VALUE_W    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ACTIVATE   = 3'd0,
    OP_SET_REL    = 3'd1,
    OP_SET_ABS    = 3'd2,
    OP_CANCEL     = 3'd3,
    OP_READ_ALARM = 3'd4,
    OP_TICK       = 3'd5,
    OP_DISPATCH   = 3'd6,
    OP_READ_TICK  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic activate;
    logic set_rel;
    logic set_abs;
    logic cancel;
    logic dispatch;
    logic tick_inc;
    logic rd_req;
    logic rd_sweep;
    logic sweep_clr;
    logic result_load;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic sweep_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/atpd_ctrl.sv
// ----------------------------------------------------------------------------
// Alarm timer dispatcher controller
// Sequences each request: decode, alarm table sweep on a tick, result load.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alarm_timer_priority_dispatcher_unit_defines.svh"

module atpd_ctrl import atpd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status_i.op)
          OP_ACTIVATE: begin
            cmd_o.activate    = 1'b1;
            cmd_o.result_load = 1'b1;
            state_nxt         = ST_IDLE;
          end
          OP_SET_REL: begin
            cmd_o.set_rel     = 1'b1;
            cmd_o.result_load = 1'b1;
            state_nxt         = ST_IDLE;
          end
          OP_SET_ABS: begin
            cmd_o.set_abs     = 1'b1;
            cmd_o.result_load = 1'b1;
            state_nxt         = ST_IDLE;
          end
          OP_CANCEL: begin
            cmd_o.cancel      = 1'b1;
            cmd_o.result_load = 1'b1;
            state_nxt         = ST_IDLE;
          end
          OP_READ_ALARM: begin
            cmd_o.rd_req = 1'b1;
            state_nxt    = ST_RESULT;
          end
          OP_TICK: begin
            cmd_o.tick_inc  = 1'b1;
            cmd_o.sweep_clr = 1'b1;
            state_nxt       = ST_SWEEP;
          end
          OP_DISPATCH: begin
            cmd_o.dispatch    = 1'b1;
            cmd_o.result_load = 1'b1;
            state_nxt         = ST_IDLE;
          end
          OP_READ_TICK: begin
            cmd_o.result_load = 1'b1;
            state_nxt         = ST_IDLE;
          end
        endcase
      end
      ST_SWEEP: begin
        // One alarm entry is read per cycle; its write-back lands in the next cycle.
        cmd_o.rd_sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        cmd_o.result_load = 1'b1;
        state_nxt         = ST_IDLE;
      end
    endcase
  end

  `ATPD_ASSERT_NEXT(a_accept_leaves_idle, (state_r == ST_IDLE) && start, state_r == ST_EXEC, "accepted request did not start execution")
  `ATPD_ASSERT(a_sweep_only_in_sweep, cmd_o.rd_sweep |-> !cmd_o.rd_req && !cmd_o.capture, "sweep read overlaps another command")

endmodule

`default_nettype wire

// File: rtl/atpd_dp.sv
// ----------------------------------------------------------------------------
// Alarm timer dispatcher datapath
// Ready map, tick counter, alarm table memories and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alarm_timer_priority_dispatcher_unit_defines.svh"

module atpd_dp import atpd_pkg::*; #(
  parameter int TASK_COUNT  = 32,
  parameter int ALARM_COUNT = 8,
  parameter int TICK_BITS   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [TASK_W-1:0]     in_task_id,
  input  wire logic [ALARM_ID_W-1:0] in_alarm_id,
  input  wire logic [VALUE_W-1:0]    in_time_value,
  input  wire logic [VALUE_W-1:0]    in_cycle_value,
  input  wire logic [TASK_W-1:0]     in_alarm_task,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 status_o,
  output logic                       out_strobe,
  output logic                       out_task_valid,
  output logic [TASK_W-1:0]          out_task_number,
  output logic                       out_idle,
  output logic [VALUE_W-1:0]         out_alarm_left,
  output logic [VALUE_W-1:0]         out_tick_now
);

  localparam int AW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;

  // Captured request
  op_t                   op_r;
  logic [TASK_W-1:0]     task_id_r;
  logic [ALARM_ID_W-1:0] alarm_id_r;
  logic [TICK_BITS-1:0]  time_r;
  logic [TICK_BITS-1:0]  cycle_r;
  logic [TASK_W-1:0]     alarm_task_r;

  // Block state
  logic [TASK_COUNT-1:0] ready_r;
  logic [TASK_COUNT-1:0] ready_nxt;
  logic [TICK_BITS-1:0]  tick_r;

  // Alarm table; an entry never set reads as all zero through its valid bit
  logic [TICK_BITS-1:0]   cd_mem  [ALARM_COUNT];
  logic [TICK_BITS-1:0]   per_mem [ALARM_COUNT];
  logic [TASK_W-1:0]      tgt_mem [ALARM_COUNT];
  logic [ALARM_COUNT-1:0] valid_r;

  logic [AW-1:0]        sweep_ptr_r;
  logic [AW-1:0]        req_addr;
  logic [AW-1:0]        rd_addr;
  logic                 req_in_range;
  logic [TICK_BITS-1:0] rd_cd_r;
  logic [TICK_BITS-1:0] rd_per_r;
  logic [TASK_W-1:0]    rd_tgt_r;
  logic                 rd_vld_r;
  logic                 wb_pend_r;
  logic [AW-1:0]        wb_addr_r;

  logic [TICK_BITS-1:0] cd_eff;
  logic [TICK_BITS-1:0] per_eff;
  logic [TASK_W-1:0]    tgt_eff;
  logic [TICK_BITS-1:0] cd_dec;
  logic                 wb_live;
  logic                 wb_expire;
  logic [TICK_BITS-1:0] set_cd;
  logic                 set_en;
  logic                 cancel_en;
  logic                 cd_we;
  logic                 per_we;
  logic [AW-1:0]        wr_addr;
  logic [TICK_BITS-1:0] wr_cd;
  logic [TICK_BITS-1:0] wr_per;

  logic                  found;
  logic [TASK_W-1:0]     hi_idx;
  logic [TASK_COUNT-1:0] set_mask;
  logic [TASK_COUNT-1:0] clr_mask;
  logic                  dispatching;

  logic                  out_strobe_r;
  logic                  out_task_valid_r;
  logic [TASK_W-1:0]     out_task_number_r;
  logic                  out_idle_r;
  logic [VALUE_W-1:0]    out_alarm_left_r;
  logic [VALUE_W-1:0]    out_tick_now_r;

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      op_r         <= op_t'(in_op);
      task_id_r    <= in_task_id;
      alarm_id_r   <= in_alarm_id;
      time_r       <= TICK_BITS'(in_time_value);
      cycle_r      <= TICK_BITS'(in_cycle_value);
      alarm_task_r <= in_alarm_task;
    end
  end

  assign req_in_range = (32'(alarm_id_r) < 32'(ALARM_COUNT));
  assign req_addr     = AW'(alarm_id_r);
  assign rd_addr      = cmd_i.rd_sweep ? sweep_ptr_r : req_addr;

  assign status_o.op         = op_r;
  assign status_o.sweep_last = (sweep_ptr_r == AW'(ALARM_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_ptr_r <= '0;
      wb_pend_r   <= 1'b0;
    end else begin
      if (cmd_i.sweep_clr) begin
        sweep_ptr_r <= '0;
      end else if (cmd_i.rd_sweep) begin
        sweep_ptr_r <= sweep_ptr_r + AW'(1);
      end
      wb_pend_r <= cmd_i.rd_sweep;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= rd_addr;
    if (cmd_i.rd_req || cmd_i.rd_sweep) begin
      rd_cd_r  <= cd_mem[rd_addr];
      rd_per_r <= per_mem[rd_addr];
      rd_tgt_r <= tgt_mem[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // Tick write-back: count down, and on reaching zero reload and mark the target.
  always_comb begin
    cd_eff    = rd_vld_r ? rd_cd_r  : '0;
    per_eff   = rd_vld_r ? rd_per_r : '0;
    tgt_eff   = rd_vld_r ? rd_tgt_r : '0;
    cd_dec    = cd_eff - TICK_BITS'(1);
    wb_live   = wb_pend_r && (cd_eff != '0);
    wb_expire = wb_live && (cd_dec == '0);
    set_cd    = cmd_i.set_rel ? time_r : (time_r - tick_r);
    set_en    = (cmd_i.set_rel || cmd_i.set_abs) && req_in_range;
    cancel_en = cmd_i.cancel && req_in_range;
    cd_we     = wb_live || set_en || cancel_en;
    per_we    = set_en || cancel_en;
    wr_addr   = wb_live ? wb_addr_r : req_addr;
    wr_per    = set_en ? cycle_r : '0;
    if (wb_live) begin
      wr_cd = wb_expire ? per_eff : cd_dec;
    end else if (set_en) begin
      wr_cd = set_cd;
    end else begin
      wr_cd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cd_we) begin
      cd_mem[wr_addr] <= wr_cd;
    end
    if (per_we) begin
      per_mem[wr_addr] <= wr_per;
    end
    if (set_en) begin
      tgt_mem[wr_addr] <= alarm_task_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (set_en) begin
      valid_r[req_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (cmd_i.tick_inc) begin
      tick_r <= tick_r + TICK_BITS'(1);
    end
  end

  // Highest-numbered ready task wins.
  always_comb begin
    found  = 1'b0;
    hi_idx = '0;
    for (int i = 0; i < TASK_COUNT; i++) begin
      if (ready_r[i]) begin
        found  = 1'b1;
        hi_idx = TASK_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TASK_COUNT; i++) begin
      set_mask[i] = (cmd_i.activate && (task_id_r == TASK_W'(i))) ||
                    (wb_expire && (tgt_eff == TASK_W'(i)));
      clr_mask[i] = cmd_i.dispatch && found && (hi_idx == TASK_W'(i));
    end
    ready_nxt = (ready_r & ~clr_mask) | set_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= '0;
    end else begin
      ready_r <= ready_nxt;
    end
  end

  assign dispatching = (op_r == OP_DISPATCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd_i.result_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.result_load) begin
      out_task_valid_r  <= dispatching && found;
      out_task_number_r <= (dispatching && found) ? hi_idx : '0;
      out_idle_r        <= dispatching && !found;
      out_alarm_left_r  <= ((op_r == OP_READ_ALARM) && req_in_range && rd_vld_r) ?
                           VALUE_W'(rd_cd_r) : '0;
      out_tick_now_r    <= VALUE_W'(tick_r);
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_task_valid  = out_task_valid_r;
  assign out_task_number = out_task_number_r;
  assign out_idle        = out_idle_r;
  assign out_alarm_left  = out_alarm_left_r;
  assign out_tick_now    = out_tick_now_r;

  `ATPD_ASSERT(a_valid_idle_excl, out_strobe_r |-> !(out_task_valid_r && out_idle_r), "dispatch reported both a task and idle")
  `ATPD_ASSERT(a_wb_no_overlap, wb_pend_r |-> !(cmd_i.set_rel || cmd_i.set_abs || cmd_i.cancel), "alarm write-back collides with a table update")

endmodule

`default_nettype wire

// File: rtl/alarm_timer_priority_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// Alarm timer with priority dispatcher
// Ready bitmap, tick counter and alarm table behind a start/busy request port.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and every request
// gives exactly one result, shown for a single cycle with out_strobe; the
// receiver cannot hold it off. Activate, set, cancel, dispatch and read tick
// load their result in the execute state; read alarm loads it in a result
// state after its table read, and a tick reaches that state after walking the
// alarm table one entry per cycle through its single write port. A new request
// can be accepted in the cycle that the previous result is strobed. The alarm
// table needs no clearing pass after reset.
`default_nettype none
`include "alarm_timer_priority_dispatcher_unit_defines.svh"

module alarm_timer_priority_dispatcher_unit import atpd_pkg::*; #(
  parameter int TASK_COUNT  = 32,
  parameter int ALARM_COUNT = 8,
  parameter int TICK_BITS   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [TASK_W-1:0]     in_task_id,
  input  wire logic [ALARM_ID_W-1:0] in_alarm_id,
  input  wire logic [VALUE_W-1:0]    in_time_value,
  input  wire logic [VALUE_W-1:0]    in_cycle_value,
  input  wire logic [TASK_W-1:0]     in_alarm_task,
  output logic                       out_strobe,
  output logic                       out_task_valid,
  output logic [TASK_W-1:0]          out_task_number,
  output logic                       out_idle,
  output logic [VALUE_W-1:0]         out_alarm_left,
  output logic [VALUE_W-1:0]         out_tick_now
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  atpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  atpd_dp #(
    .TASK_COUNT  (TASK_COUNT),
    .ALARM_COUNT (ALARM_COUNT),
    .TICK_BITS   (TICK_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_task_id      (in_task_id),
    .in_alarm_id     (in_alarm_id),
    .in_time_value   (in_time_value),
    .in_cycle_value  (in_cycle_value),
    .in_alarm_task   (in_alarm_task),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_strobe      (out_strobe),
    .out_task_valid  (out_task_valid),
    .out_task_number (out_task_number),
    .out_idle        (out_idle),
    .out_alarm_left  (out_alarm_left),
    .out_tick_now    (out_tick_now)
  );

  `ATPD_ASSERT(a_strobe_when_free, out_strobe |-> !busy, "result strobed while a request is still in progress")
  `ATPD_ASSERT_NEXT(a_single_strobe, out_strobe, !out_strobe, "two results strobed back to back")
  `ATPD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm timer dispatcher testbench
// Drives activate, alarm set/cancel/read, tick, dispatch and tick-read
// requests through the start/busy port, with random idle bursts. Each accepted
// request is applied to a local model of the ready bitmap, tick counter and
// alarm table. Every strobed result is then checked field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import atpd_pkg::*;

  localparam int TASKS  = 32;
  localparam int ALARMS = 8;
  localparam int RANDOM_REQUESTS = 450;

  typedef struct packed {
    op_t                     op;
    logic [TASK_W-1:0]       task_id;
    logic [ALARM_ID_W-1:0]   alarm_id;
    logic [VALUE_W-1:0]      time_value;
    logic [VALUE_W-1:0]      cycle_value;
    logic [TASK_W-1:0]       alarm_task;
  } request_t;

  typedef struct packed {
    logic                    task_valid;
    logic [TASK_W-1:0]       task_number;
    logic                    idle;
    logic [VALUE_W-1:0]      alarm_left;
    logic [VALUE_W-1:0]      tick_now;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OP_W-1:0]       in_op = '0;
  logic [TASK_W-1:0]     in_task_id = '0;
  logic [ALARM_ID_W-1:0] in_alarm_id = '0;
  logic [VALUE_W-1:0]    in_time_value = '0;
  logic [VALUE_W-1:0]    in_cycle_value = '0;
  logic [TASK_W-1:0]     in_alarm_task = '0;
  logic                  out_strobe;
  logic                  out_task_valid;
  logic [TASK_W-1:0]     out_task_number;
  logic                  out_idle;
  logic [VALUE_W-1:0]    out_alarm_left;
  logic [VALUE_W-1:0]    out_tick_now;

  // Local copy of the dispatcher state.
  logic [TASKS-1:0]   ready_bits = '0;
  logic [VALUE_W-1:0] tick_count = '0;
  logic [VALUE_W-1:0] countdown [ALARMS];
  logic [VALUE_W-1:0] reload [ALARMS];
  logic [TASK_W-1:0]  target_task [ALARMS];

  request_t queued_requests [$];
  outcome_t due_outcomes [$];
  request_t on_ports;
  int       gap_left = 0;
  int       accepted = 0;
  int       total_requests = 0;
  int       results_seen = 0;
  int       error_count = 0;
  int       expiries = 0;
  int       tasks_dispatched = 0;
  int       op_seen [8];
  logic [VALUE_W-1:0] ticks_queued = '0;

  alarm_timer_priority_dispatcher_unit #(
    .TASK_COUNT  (TASKS),
    .ALARM_COUNT (ALARMS),
    .TICK_BITS   (VALUE_W)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_task_id      (in_task_id),
    .in_alarm_id     (in_alarm_id),
    .in_time_value   (in_time_value),
    .in_cycle_value  (in_cycle_value),
    .in_alarm_task   (in_alarm_task),
    .out_strobe      (out_strobe),
    .out_task_valid  (out_task_valid),
    .out_task_number (out_task_number),
    .out_idle        (out_idle),
    .out_alarm_left  (out_alarm_left),
    .out_tick_now    (out_tick_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int a = 0; a < ALARMS; a++) begin
      countdown[a] = '0;
      reload[a] = '0;
      target_task[a] = '0;
    end
    foreach (op_seen[i]) op_seen[i] = 0;
  end

  task automatic flag_error(input string msg);
    if (error_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [VALUE_W-1:0] got,
                             input logic [VALUE_W-1:0] want, input int seq);
    if (got !== want)
      flag_error($sformatf("result %0d %s: got 0x%0h, predicted 0x%0h", seq, name, got, want));
  endtask

  // Applies one accepted request to the local state and returns its result.
  function automatic outcome_t step_alarm_table(input request_t rq);
    outcome_t res;
    int       t;
    res = '0;
    op_seen[int'(rq.op)]++;
    case (rq.op)
      OP_ACTIVATE: begin
        if (int'(rq.task_id) < TASKS) ready_bits[rq.task_id] = 1'b1;
      end
      OP_SET_REL, OP_SET_ABS: begin
        if (int'(rq.alarm_id) < ALARMS) begin
          countdown[rq.alarm_id] = (rq.op == OP_SET_REL) ? rq.time_value
                                                         : rq.time_value - tick_count;
          reload[rq.alarm_id] = rq.cycle_value;
          target_task[rq.alarm_id] = rq.alarm_task;
        end
      end
      OP_CANCEL: begin
        if (int'(rq.alarm_id) < ALARMS) begin
          countdown[rq.alarm_id] = '0;
          reload[rq.alarm_id] = '0;
        end
      end
      OP_READ_ALARM: begin
        if (int'(rq.alarm_id) < ALARMS) res.alarm_left = countdown[rq.alarm_id];
      end
      OP_TICK: begin
        tick_count = tick_count + VALUE_W'(1);
        for (int a = 0; a < ALARMS; a++) begin
          if (countdown[a] != '0) begin
            countdown[a] = countdown[a] - VALUE_W'(1);
            if (countdown[a] == '0) begin
              expiries++;
              if (int'(target_task[a]) < TASKS) ready_bits[target_task[a]] = 1'b1;
              countdown[a] = reload[a];
            end
          end
        end
      end
      OP_DISPATCH: begin
        if (ready_bits != '0) begin
          t = TASKS - 1;
          while (!ready_bits[t]) t--;
          res.task_valid = 1'b1;
          res.task_number = t[TASK_W-1:0];
          ready_bits[t] = 1'b0;
          tasks_dispatched++;
        end else begin
          res.idle = 1'b1;
        end
      end
      default: ;
    endcase
    res.tick_now = tick_count;
    return res;
  endfunction

  task automatic queue_request(input op_t op, input logic [TASK_W-1:0] tid,
                               input logic [ALARM_ID_W-1:0] aid,
                               input logic [VALUE_W-1:0] tv, input logic [VALUE_W-1:0] cv,
                               input logic [TASK_W-1:0] at);
    request_t rq;
    rq = '{op: op, task_id: tid, alarm_id: aid, time_value: tv, cycle_value: cv,
           alarm_task: at};
    queued_requests.push_back(rq);
    total_requests++;
    if (op == OP_TICK) ticks_queued = ticks_queued + VALUE_W'(1);
  endtask

  // Driver: a request leaves the ports once it is seen accepted; idle bursts
  // stop once only the closing stretch of requests is left.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        due_outcomes.push_back(step_alarm_table(on_ports));
        accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (queued_requests.size() > 60 && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 9);
          start <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          on_ports = queued_requests.pop_front();
          start <= 1'b1;
          in_op <= on_ports.op;
          in_task_id <= on_ports.task_id;
          in_alarm_id <= on_ports.alarm_id;
          in_time_value <= on_ports.time_value;
          in_cycle_value <= on_ports.cycle_value;
          in_alarm_task <= on_ports.alarm_task;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is one result and cannot be held off.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_strobe === 1'b1) begin
      results_seen++;
      if (due_outcomes.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no request outstanding", results_seen));
      end else begin
        want = due_outcomes.pop_front();
        check_field("task_valid", VALUE_W'(out_task_valid), VALUE_W'(want.task_valid),
                    results_seen);
        check_field("task_number", VALUE_W'(out_task_number), VALUE_W'(want.task_number),
                    results_seen);
        check_field("idle", VALUE_W'(out_idle), VALUE_W'(want.idle), results_seen);
        check_field("alarm_left", out_alarm_left, want.alarm_left, results_seen);
        check_field("tick_now", out_tick_now, want.tick_now, results_seen);
      end
    end
  end

  initial begin
    op_t                   op;
    logic [TASK_W-1:0]     tid;
    logic [ALARM_ID_W-1:0] aid;
    logic [VALUE_W-1:0]    tv;
    logic [VALUE_W-1:0]    cv;
    logic [TASK_W-1:0]     at;
    int                    pick;
    int                    drain;
    bit                    wide;

    // Directed: empty dispatch, priority order, zero countdowns, one-shot and
    // periodic expiry, absolute set behind the counter, cancel.
    queue_request(OP_READ_TICK, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_DISPATCH, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_ACTIVATE, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_ACTIVATE, 5'd31, 3'd0, '0, '0, 5'd0);
    queue_request(OP_ACTIVATE, 5'd17, 3'd0, '0, '0, 5'd0);
    queue_request(OP_DISPATCH, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_DISPATCH, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_DISPATCH, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_SET_REL, 5'd0, 3'd0, 32'd0, 32'd3, 5'd9);
    queue_request(OP_READ_ALARM, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_SET_REL, 5'd0, 3'd7, 32'd2, 32'd0, 5'd5);
    queue_request(OP_SET_REL, 5'd0, 3'd3, 32'd1, 32'd1, 5'd31);
    queue_request(OP_SET_ABS, 5'd0, 3'd1, ticks_queued, 32'd4, 5'd2);
    queue_request(OP_SET_ABS, 5'd0, 3'd2, ticks_queued - VALUE_W'(1), 32'hFFFF_FFFF, 5'd12);
    queue_request(OP_READ_ALARM, 5'd0, 3'd2, '0, '0, 5'd0);
    queue_request(OP_TICK, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_TICK, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_READ_ALARM, 5'd0, 3'd7, '0, '0, 5'd0);
    queue_request(OP_DISPATCH, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_DISPATCH, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_CANCEL, 5'd0, 3'd3, '0, '0, 5'd0);
    queue_request(OP_READ_ALARM, 5'd0, 3'd3, '0, '0, 5'd0);
    queue_request(OP_SET_REL, 5'd0, 3'd4, 32'hFFFF_FFFF, 32'd0, 5'd0);
    queue_request(OP_TICK, 5'd0, 3'd0, '0, '0, 5'd0);
    queue_request(OP_READ_TICK, 5'd0, 3'd0, '0, '0, 5'd0);

    // Random: mostly short countdowns and periods so that alarms really expire,
    // with the odd full-width value; unused fields always carry noise.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      wide = ($urandom_range(0, 11) == 0);
      tid = TASK_W'($urandom);
      aid = ALARM_ID_W'($urandom);
      tv = $urandom;
      cv = $urandom;
      at = TASK_W'($urandom);
      if (pick < 30) begin
        op = OP_TICK;
      end else if (pick < 45) begin
        op = OP_DISPATCH;
      end else if (pick < 55) begin
        op = OP_ACTIVATE;
      end else if (pick < 67) begin
        op = OP_SET_REL;
        if (!wide) begin
          tv = $urandom_range(0, 6);
          cv = $urandom_range(0, 5);
        end
      end else if (pick < 77) begin
        op = OP_SET_ABS;
        if (!wide) begin
          tv = ticks_queued + VALUE_W'($urandom_range(0, 7)) - VALUE_W'(1);
          cv = $urandom_range(0, 5);
        end
      end else if (pick < 82) begin
        op = OP_CANCEL;
      end else if (pick < 94) begin
        op = OP_READ_ALARM;
      end else begin
        op = OP_READ_TICK;
      end
      queue_request(op, tid, aid, tv, cv, at);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < total_requests) @(posedge clk);
    drain = 0;
    while (due_outcomes.size() != 0 && drain < 200) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (due_outcomes.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", due_outcomes.size()));

    $display("summary: %0d requests, %0d ticks, %0d dispatches, %0d results checked",
             accepted, op_seen[int'(OP_TICK)], op_seen[int'(OP_DISPATCH)], results_seen);
    $display("summary: %0d alarm expiries, %0d tasks dispatched, %0d mismatches",
             expiries, tasks_dispatched, error_count);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d of %0d requests accepted", accepted, total_requests);
    $display("tb_top: errors");
    $finish;
  end

endmodule
